>>> rtl/core/xsrg_pkg.sv
`default_nettype none

package xsrg_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  localparam logic [1:0] OP_RAW    = 2'd0;
  localparam logic [1:0] OP_RANGE  = 2'd1;
  localparam logic [1:0] OP_RESEED = 2'd2;
  localparam logic [1:0] OP_HASH   = 2'd3;

  localparam word_t WORD_A_RST = 32'd207555608;
  localparam word_t WORD_B_RST = 32'd4002963216;
  localparam word_t WORD_C_RST = 32'd4126398668;
  localparam word_t WORD_D_RST = 32'd2552396014;

  typedef struct packed {
    logic [1:0]        operation;
    word_t             seed_or_value;
    logic signed [WordW-1:0] range_low;
    logic signed [WordW-1:0] range_high;
  } in_t;

  typedef struct packed {
    word_t             raw_word;
    logic signed [WordW-1:0] ranged_value;
    logic              span_empty;
  } out_t;

  // Single xorshift32 round with shifts 13, 17, 5.
  function automatic word_t xs32(input word_t v);
    word_t t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // New newest word of the xorshift128 sequence.
  function automatic word_t xs128_next(input word_t a, input word_t d);
    word_t t;
    t = a ^ (a << 11);
    return (d ^ (d >> 19)) ^ (t ^ (t >> 8));
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/xorshift128_range_generator.sv
// Flow: a raw draw, a hash or an equal-bounds ranged draw goes from acceptance straight to
// the finish state, a reseed through the seed state, a nonzero-span ranged draw through the divide state.
// From the finish state the result moves into the output register once that register is free.
// Throughput: one transaction at a time, accepted only once the last result has left the finish
// state; the radix-2 remainder loop works one quotient bit per cycle.
// Reset: asynchronous, active low; the state words load their fixed seed values
// and both channels come up empty.
`default_nettype none

module xorshift128_range_generator
  import xsrg_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEED,
    ST_DIV,
    ST_FINISH
  } state_e;

  localparam int unsigned CntW = $clog2(WordW);

  state_e          state_q;
  word_t           word_a_q, word_b_q, word_c_q, word_d_q;
  word_t           span_q, mn_q, dividend_q, rem_q;
  logic [CntW-1:0] cnt_q;
  out_t            res_q;
  out_t            out_q;
  logic            out_valid_q;

  logic            in_fire;
  logic            out_load;
  logic            swap;
  word_t           mn, mx, span, next_d;
  logic [WordW:0]  rem_shift;
  logic [WordW:0]  rem_sub;
  word_t           rem_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  assign swap   = in_data_i.range_low > in_data_i.range_high;
  assign mn     = swap ? word_t'(in_data_i.range_high) : word_t'(in_data_i.range_low);
  assign mx     = swap ? word_t'(in_data_i.range_low) : word_t'(in_data_i.range_high);
  assign span   = mx - mn;
  assign next_d = xs128_next(word_a_q, word_d_q);

  // One restoring step: bring in the next dividend bit, subtract the span if it fits.
  assign rem_shift = {rem_q, dividend_q[WordW-1]};
  assign rem_sub   = rem_shift - {1'b0, span_q};
  assign rem_d     = rem_sub[WordW] ? rem_shift[WordW-1:0] : rem_sub[WordW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      word_a_q    <= WORD_A_RST;
      word_b_q    <= WORD_B_RST;
      word_c_q    <= WORD_C_RST;
      word_d_q    <= WORD_D_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            cnt_q <= '0;
            case (in_data_i.operation)
              OP_RAW, OP_RANGE: begin
                word_a_q       <= word_b_q;
                word_b_q       <= word_c_q;
                word_c_q       <= word_d_q;
                word_d_q       <= next_d;
                span_q         <= span;
                mn_q           <= mn;
                dividend_q     <= next_d;
                rem_q          <= '0;
                if (in_data_i.operation == OP_RANGE && span == '0) begin
                  res_q   <= '{raw_word: next_d, ranged_value: $signed(mn), span_empty: 1'b1};
                  state_q <= ST_FINISH;
                end else if (in_data_i.operation == OP_RANGE) begin
                  res_q   <= '{raw_word: next_d, ranged_value: '0, span_empty: 1'b0};
                  state_q <= ST_DIV;
                end else begin
                  res_q   <= '{raw_word: next_d, ranged_value: '0, span_empty: 1'b0};
                  state_q <= ST_FINISH;
                end
              end
              OP_RESEED: begin
                word_a_q <= in_data_i.seed_or_value;
                word_b_q <= xs32(in_data_i.seed_or_value);
                res_q    <= '0;
                state_q  <= ST_SEED;
              end
              default: begin
                res_q   <= '{raw_word: xs32(in_data_i.seed_or_value), ranged_value: '0,
                            span_empty: 1'b0};
                state_q <= ST_FINISH;
              end
            endcase
          end
        end
        ST_SEED: begin
          // The chain continues one derived word per cycle.
          if (cnt_q == '0) begin
            word_c_q <= xs32(word_b_q);
            cnt_q    <= cnt_q + 1'b1;
          end else begin
            word_d_q       <= xs32(word_c_q);
            res_q.raw_word <= xs32(word_c_q);
            cnt_q          <= '0;
            state_q        <= ST_FINISH;
          end
        end
        ST_DIV: begin
          // The counter wraps back to zero after the last step.
          rem_q      <= rem_d;
          dividend_q <= {dividend_q[WordW-2:0], 1'b0};
          cnt_q      <= cnt_q + 1'b1;
          if (cnt_q == CntW'(WordW - 1)) begin
            res_q.ranged_value <= $signed(rem_d + mn_q);
            state_q            <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The partial remainder never reaches the divisor while the loop runs.
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("partial remainder not below span");

  // A new result is loaded into the output register only from the finish state.
  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result loaded outside finish state");

  // An accepted item always blocks the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input ready right after acceptance");

  // The step counter is idle outside the iterating states.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_FINISH) |-> (cnt_q == '0))
    else $error("step counter not cleared");

endmodule

`default_nettype wire

>>> verif/xsrg_result_monitor.sv
`default_nettype none

module xsrg_result_monitor
  import xsrg_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  input  wire  in_ready_i,
  input  in_t  in_data_i,
  input  wire  out_valid_i,
  input  wire  out_ready_i,
  input  out_t out_data_i,
  output int   mismatch_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Generator words, oldest first.
  word_t gen_w0, gen_w1, gen_w2, gen_w3;

  out_t predicted_results[$];
  out_t oldest;
  int   mismatches;

  function automatic word_t xorshift32_round(input word_t v);
    word_t x;
    x = v ^ (v << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

  function automatic word_t advance_generator();
    word_t t;
    t = gen_w0 ^ (gen_w0 << 11);
    gen_w0 = gen_w1;
    gen_w1 = gen_w2;
    gen_w2 = gen_w3;
    gen_w3 = (gen_w3 ^ (gen_w3 >> 19)) ^ (t ^ (t >> 8));
    return gen_w3;
  endfunction

  function automatic out_t predict_result(input in_t item);
    out_t  res;
    word_t lower, upper, span, draw;
    res = '0;
    case (item.operation)
      OP_RAW: begin
        res.raw_word = advance_generator();
      end
      OP_RANGE: begin
        lower = item.range_low;
        upper = item.range_high;
        if (item.range_low > item.range_high) begin
          lower = item.range_high;
          upper = item.range_low;
        end
        draw = advance_generator();
        res.raw_word = draw;
        // The span is an unsigned difference, so the full signed range is served.
        span = upper - lower;
        if (span == '0) begin
          res.ranged_value = lower;
          res.span_empty = 1'b1;
        end else begin
          res.ranged_value = (draw % span) + lower;
        end
      end
      OP_RESEED: begin
        gen_w0 = item.seed_or_value;
        gen_w1 = xorshift32_round(gen_w0);
        gen_w2 = xorshift32_round(gen_w1);
        gen_w3 = xorshift32_round(gen_w2);
        res.raw_word = gen_w3;
      end
      default: begin
        res.raw_word = xorshift32_round(item.seed_or_value);
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input word_t got, input word_t want);
    mismatches++;
    $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_w0 = WORD_A_RST;
      gen_w1 = WORD_B_RST;
      gen_w2 = WORD_C_RST;
      gen_w3 = WORD_D_RST;
      predicted_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with no transaction pending", out_data_i.raw_word, '0);
        end else begin
          oldest = predicted_results.pop_front();
          if (out_data_i.raw_word !== oldest.raw_word)
            report_mismatch("raw_word", out_data_i.raw_word, oldest.raw_word);
          if (out_data_i.ranged_value !== oldest.ranged_value)
            report_mismatch("ranged_value", out_data_i.ranged_value, oldest.ranged_value);
          if (out_data_i.span_empty !== oldest.span_empty)
            report_mismatch("span_empty", word_t'(out_data_i.span_empty),
                            word_t'(oldest.span_empty));
        end
      end
      if (in_valid_i && in_ready_i)
        predicted_results.push_back(predict_result(in_data_i));
    end
    mismatch_count_o <= mismatches;
    outstanding_o <= predicted_results.size();
  end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench
  import xsrg_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [WordW-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [WordW-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam int QuietLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  int mismatch_count;
  int outstanding;
  int gap_pct = 20;
  int stall_pct = 20;
  int stall_left = 0;
  int quiet_cycles = 0;
  int pct_choices[4] = '{0, 15, 40, 70};

  xorshift128_range_generator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  xsrg_result_monitor u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver back-pressure comes in bursts of random length.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < gap_pct) return $urandom_range(1, 14);
    return 0;
  endfunction

  function automatic logic signed [WordW-1:0] edge_bound();
    case ($urandom_range(0, 5))
      0: return S_MIN;
      1: return S_MAX;
      2: return '0;
      3: return '1;
      4: return 32'sd1;
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  function automatic in_t random_item();
    in_t item;
    int  pick;
    item.seed_or_value = $urandom;
    item.range_low = $urandom;
    item.range_high = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 30) item.operation = OP_RAW;
    else if (pick < 75) item.operation = OP_RANGE;
    else if (pick < 82) item.operation = OP_RESEED;
    else item.operation = OP_HASH;
    if (item.operation == OP_RESEED && $urandom_range(0, 29) == 0)
      item.seed_or_value = '0;
    if (item.operation == OP_HASH && $urandom_range(0, 9) == 0)
      item.seed_or_value = edge_bound();
    if (item.operation == OP_RANGE) begin
      case ($urandom_range(0, 4))
        0: ;
        1: begin
          item.range_low = edge_bound();
          item.range_high = edge_bound();
        end
        2: item.range_high = item.range_low + (int'($urandom_range(0, 64)) - 32);
        3: item.range_high = item.range_low;
        default: begin
          item.range_low = int'($urandom_range(0, 2000)) - 1000;
          item.range_high = int'($urandom_range(0, 2000)) - 1000;
        end
      endcase
    end
    return item;
  endfunction

  // Valid stays high between back-to-back transactions; this task drops it only for a gap.
  task automatic send_item(input in_t item, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_fields(input logic [1:0] op, input word_t value,
                             input logic signed [WordW-1:0] lo,
                             input logic signed [WordW-1:0] hi);
    in_t item;
    item.operation = op;
    item.seed_or_value = value;
    item.range_low = lo;
    item.range_high = hi;
    send_item(item, pick_gap());
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(OP_RAW, $urandom, $urandom, $urandom);
    send_fields(OP_RAW, $urandom, $urandom, $urandom);
    send_fields(OP_RANGE, $urandom, S_MIN, S_MAX);
    send_fields(OP_RANGE, $urandom, S_MAX, S_MIN);
    send_fields(OP_RANGE, $urandom, 32'sd7, 32'sd7);
    send_fields(OP_RANGE, $urandom, S_MIN, S_MIN);
    send_fields(OP_RANGE, $urandom, S_MAX, S_MAX);
    send_fields(OP_RANGE, $urandom, 32'sd0, 32'sd1);
    send_fields(OP_RANGE, $urandom, 32'sd10, -32'sd10);
    send_fields(OP_RANGE, $urandom, -32'sd1, 32'sd0);
    send_fields(OP_RANGE, $urandom, 32'sd0, -32'sd1);
    send_fields(OP_RANGE, $urandom, 32'sd1, S_MAX);
    send_fields(OP_HASH, '0, $urandom, $urandom);
    send_fields(OP_HASH, '1, $urandom, $urandom);
    send_fields(OP_HASH, 32'h8000_0000, $urandom, $urandom);
    // A zero seed leaves the generator stuck at zero until the next reseed.
    send_fields(OP_RESEED, '0, $urandom, $urandom);
    send_fields(OP_RAW, $urandom, $urandom, $urandom);
    send_fields(OP_RANGE, $urandom, -32'sd5, 32'sd5);
    send_fields(OP_HASH, 32'd1, $urandom, $urandom);
    send_fields(OP_RESEED, '1, $urandom, $urandom);
    send_fields(OP_RAW, $urandom, $urandom, $urandom);
    send_fields(OP_RESEED, 32'd1, $urandom, $urandom);
    send_fields(OP_RANGE, $urandom, S_MIN, -32'sd1);
    send_fields(OP_RAW, $urandom, $urandom, $urandom);
    drain_results();

    for (int chunk = 0; chunk < 7; chunk++) begin
      gap_pct = pct_choices[$urandom_range(0, 3)];
      stall_pct = pct_choices[$urandom_range(0, 3)];
      for (int n = 0; n < 200; n++) send_item(random_item(), pick_gap());
      if (chunk == 3) drain_results();
    end

    gap_pct = 0;
    stall_pct = 0;
    for (int n = 0; n < 400; n++) send_item(random_item(), 0);

    drain_results();
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/core/xsrg_pkg.sv
rtl/core/xorshift128_range_generator.sv
verif/xsrg_result_monitor.sv
verif/testbench.sv
